[hw/rtl/bgd_pkg.sv]
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants for the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

    localparam int NUM_KEYS   = 8;
    localparam int TIME_WIDTH = 32;
    localparam int KEY_W      = 3;
    localparam int KEY_IDX_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int MASK_W     = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_W-1:0] DBL_WINDOW_RST = CFG_W'(400);
    localparam logic [CFG_W-1:0] LONG_TIME_RST  = CFG_W'(800);
    localparam logic [CFG_W-1:0] REPEAT_RST     = CFG_W'(400);

    typedef logic [TIME_WIDTH-1:0] stamp_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ACTIVE_MASK = 2'd0,
        REG_DBL_WINDOW  = 2'd1,
        REG_LONG_TIME   = 2'd2,
        REG_REPEAT      = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_CLICK   = 3'd3,
        EV_DOUBLE  = 3'd4,
        EV_LONG    = 3'd5
    } event_t;

    typedef struct packed {
        logic [MASK_W-1:0] active_level_mask;
        logic [CFG_W-1:0]  double_click_window;
        logic [CFG_W-1:0]  long_press_time;
        logic [CFG_W-1:0]  repeat_period;
    } cfg_t;

    typedef struct packed {
        logic   was_pressed;
        logic   release_pending;
        logic   click_pending;
        logic   long_armed;
        logic   first_click_seen;
        stamp_t repeat_stamp;
        stamp_t long_stamp;
        stamp_t click_stamp;
        event_t last_event;
    } key_state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_echo;
        event_t           event_code;
        logic             press_fired;
        logic             release_fired;
        logic             click_fired;
        logic             double_fired;
        logic             long_fired;
    } result_t;

endpackage

[hw/rtl/bgd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bgd_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module bgd_cfg_regs
    import bgd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_ACTIVE_MASK: cfg_next.active_level_mask   = cfg_wdata[MASK_W-1:0];
                REG_DBL_WINDOW:  cfg_next.double_click_window = cfg_wdata;
                REG_LONG_TIME:   cfg_next.long_press_time     = cfg_wdata;
                REG_REPEAT:      cfg_next.repeat_period       = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_level_mask   <= '0;
            cfg_reg.double_click_window <= DBL_WINDOW_RST;
            cfg_reg.long_press_time     <= LONG_TIME_RST;
            cfg_reg.repeat_period       <= REPEAT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/bgd_key_state.sv]
// ----------------------------------------------------------------------------
// bgd_key_state
// Per-key state registers with one read and one write port.
// ----------------------------------------------------------------------------
module bgd_key_state
    import bgd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [KEY_IDX_W-1:0] rd_idx,
    output key_state_t           rd_state,
    input  logic                 wr_en,
    input  logic [KEY_IDX_W-1:0] wr_idx,
    input  key_state_t           wr_state
);

    key_state_t state_reg [NUM_KEYS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            state_reg[wr_idx] <= wr_state;
        end
    end

    assign rd_state = state_reg[rd_idx];

endmodule

[hw/rtl/bgd_gesture_logic.sv]
// ----------------------------------------------------------------------------
// bgd_gesture_logic
// Next-state and event decode for one scan of one key.
// ----------------------------------------------------------------------------
module bgd_gesture_logic
    import bgd_pkg::*;
(
    input  cfg_t             cfg,
    input  logic [KEY_W-1:0] key,
    input  logic             level,
    input  stamp_t           now,
    input  key_state_t       cur,
    output logic             in_range,
    output key_state_t       nxt,
    output result_t          res
);

    logic   pressed;
    logic   rising;
    stamp_t rep_elapsed;
    stamp_t long_elapsed;
    stamp_t click_elapsed;

    assign in_range = (32'(key) < NUM_KEYS);

    always_comb
    begin
        pressed       = cfg.active_level_mask[key] ? level : !level;
        rising        = pressed && !cur.was_pressed;
        rep_elapsed   = now - cur.repeat_stamp;
        click_elapsed = now - cur.click_stamp;

        nxt             = cur;
        nxt.was_pressed = pressed;
        res             = '0;
        res.key_echo    = key;
        res.event_code  = cur.last_event;

        if (!pressed)
        begin
            if (!cur.release_pending)
            begin
                res.event_code = EV_NONE;
            end
            else
            begin
                res.event_code      = EV_RELEASE;
                res.release_fired   = 1'b1;
                nxt.release_pending = 1'b0;
                if (cur.click_pending)
                begin
                    res.event_code    = EV_CLICK;
                    res.click_fired   = 1'b1;
                    nxt.click_pending = 1'b0;
                    if (!cur.first_click_seen)
                    begin
                        nxt.click_stamp      = now;
                        nxt.first_click_seen = 1'b1;
                    end
                    else if (click_elapsed < stamp_t'(cfg.double_click_window))
                    begin
                        res.event_code       = EV_DOUBLE;
                        res.double_fired     = 1'b1;
                        nxt.first_click_seen = 1'b0;
                    end
                    else
                    begin
                        nxt.click_stamp = now;
                    end
                end
            end
        end
        else if (rising)
        begin
            res.event_code      = EV_PRESS;
            res.press_fired     = 1'b1;
            nxt.release_pending = 1'b1;
            nxt.click_pending   = 1'b1;
            nxt.repeat_stamp    = now;
            nxt.long_armed      = 1'b1;
            nxt.long_stamp      = now;
        end
        else if (rep_elapsed >= stamp_t'(cfg.repeat_period))
        begin
            res.event_code    = EV_PRESS;
            res.press_fired   = 1'b1;
            nxt.click_pending = 1'b0;
            nxt.repeat_stamp  = now;
        end

        long_elapsed = now - nxt.long_stamp;
        if (pressed && nxt.long_armed && (long_elapsed >= stamp_t'(cfg.long_press_time)))
        begin
            res.event_code    = EV_LONG;
            res.long_fired    = 1'b1;
            nxt.click_pending = 1'b0;
            nxt.long_armed    = 1'b0;
        end

        nxt.last_event = res.event_code;

        if (!in_range)
        begin
            nxt            = cur;
            res            = '0;
            res.key_echo   = key;
            res.event_code = EV_NONE;
        end
    end

endmodule

[hw/rtl/button_gesture_detector_unit.sv]
// ----------------------------------------------------------------------------
// button_gesture_detector_unit
// Click, double click, long press and auto-repeat detector for scanned keys.
// Each scan goes through the input register, then the result register.
// Throughput: one scan per cycle unless the result stalls; per-key state is
// updated as the result loads. A stalled result holds while one more scan
// waits in the input register. Reset: asynchronous, active low; clears all key
// state and loads the configuration defaults.
// ----------------------------------------------------------------------------
module button_gesture_detector_unit
    import bgd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [2:0] key_index, [3] raw_level, [35:4] now_ms, [39:36] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] key_echo, [5:3] event_code, [6] press_fired, [7] release_fired,
    // [8] click_fired, [9] double_fired, [10] long_fired, [15:11] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    cfg_t             cfg;
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [KEY_W-1:0] in_key_reg;
    logic             in_level_reg;
    stamp_t           in_now_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_res_reg;
    logic             advance;
    logic             in_take;
    key_state_t       cur_state;
    key_state_t       nxt_state;
    result_t          res;
    logic             in_range;

    bgd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bgd_key_state u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (in_key_reg[KEY_IDX_W-1:0]),
        .rd_state (cur_state),
        .wr_en    (advance && in_range),
        .wr_idx   (in_key_reg[KEY_IDX_W-1:0]),
        .wr_state (nxt_state)
    );

    bgd_gesture_logic u_logic (
        .cfg      (cfg),
        .key      (in_key_reg),
        .level    (in_level_reg),
        .now      (in_now_reg),
        .cur      (cur_state),
        .in_range (in_range),
        .nxt      (nxt_state),
        .res      (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_key_reg   <= s_tdata[KEY_W-1:0];
            in_level_reg <= s_tdata[KEY_W];
            in_now_reg   <= stamp_t'(s_tdata[KEY_W+32:KEY_W+1]);
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       out_res_reg.long_fired,
                       out_res_reg.double_fired,
                       out_res_reg.click_fired,
                       out_res_reg.release_fired,
                       out_res_reg.press_fired,
                       out_res_reg.event_code,
                       out_res_reg.key_echo};

endmodule

[tb/tb_button_gesture_detector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_gesture_detector_unit
// Self-checking bench for the button gesture detector. Scans are streamed in
// bursts with random gaps while the result side stalls on its own pattern.
// An internal key-state predictor computes each expected result as its scan
// transfer is accepted, and every result transfer is compared field by field.
// The run walks through several register settings, extremes included, with
// short directed gesture sequences followed by random gestures and noise.
// ----------------------------------------------------------------------------
module tb_button_gesture_detector_unit;
    import bgd_pkg::*;

    localparam int ITEMS_PER_PHASE = 80;
    localparam int NUM_PHASES      = 6;

    typedef struct packed {
        stamp_t           now;
        logic             raw;
        logic [KEY_W-1:0] key;
    } scan_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    cfg_t       shadow_cfg;
    key_state_t key_st [NUM_KEYS];
    scan_t      scan_q [$];
    result_t    expected_results [$];
    stamp_t     tick;

    logic scan_taken = 1'b0;
    int   gap_left = 0;
    int   burst_left = 0;
    int   stall_mode = 0;
    int   stall_left = 0;
    int   pat_cnt = 0;

    int fail_count = 0;
    int scans_queued = 0;
    int results_seen = 0;
    int n_press = 0;
    int n_release = 0;
    int n_click = 0;
    int n_double = 0;
    int n_long = 0;

    button_gesture_detector_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: %0d scans queued, %0d results seen", scans_queued, results_seen);
        $display("CHECKS FAILED");
        $finish;
    end

    // Per-key gesture state update for one scan; returns the expected result.
    function automatic result_t predict_scan(logic [KEY_W-1:0] key, logic raw, stamp_t now);
        result_t    r;
        key_state_t st;
        logic       pressed;
        logic       rising;
        event_t     ev;
        r = '0;
        st = key_st[key];
        pressed = shadow_cfg.active_level_mask[key] ? raw : !raw;
        rising = pressed && !st.was_pressed;
        st.was_pressed = pressed;
        ev = st.last_event;
        if (!pressed)
        begin
            if (!st.release_pending)
                ev = EV_NONE;
            else
            begin
                ev = EV_RELEASE;
                r.release_fired = 1'b1;
                st.release_pending = 1'b0;
                if (st.click_pending)
                begin
                    ev = EV_CLICK;
                    r.click_fired = 1'b1;
                    st.click_pending = 1'b0;
                    if (!st.first_click_seen)
                    begin
                        st.click_stamp = now;
                        st.first_click_seen = 1'b1;
                    end
                    else if (stamp_t'(now - st.click_stamp) <
                             stamp_t'(shadow_cfg.double_click_window))
                    begin
                        ev = EV_DOUBLE;
                        r.double_fired = 1'b1;
                        st.first_click_seen = 1'b0;
                    end
                    else
                        st.click_stamp = now;
                end
            end
        end
        else if (rising)
        begin
            ev = EV_PRESS;
            r.press_fired = 1'b1;
            st.release_pending = 1'b1;
            st.click_pending = 1'b1;
            st.repeat_stamp = now;
            st.long_armed = 1'b1;
            st.long_stamp = now;
        end
        else if (stamp_t'(now - st.repeat_stamp) >= stamp_t'(shadow_cfg.repeat_period))
        begin
            ev = EV_PRESS;
            r.press_fired = 1'b1;
            st.click_pending = 1'b0;
            st.repeat_stamp = now;
        end
        if (pressed && st.long_armed &&
            stamp_t'(now - st.long_stamp) >= stamp_t'(shadow_cfg.long_press_time))
        begin
            ev = EV_LONG;
            r.long_fired = 1'b1;
            st.click_pending = 1'b0;
            st.long_armed = 1'b0;
        end
        st.last_event = ev;
        key_st[key] = st;
        r.key_echo = key;
        r.event_code = ev;
        n_press += r.press_fired;
        n_release += r.release_fired;
        n_click += r.click_fired;
        n_double += r.double_fired;
        n_long += r.long_fired;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void push_scan(logic [KEY_W-1:0] key, logic raw, stamp_t now);
        scan_t it;
        it.key = key;
        it.raw = raw;
        it.now = now;
        scan_q.push_back(it);
        scans_queued++;
    endfunction

    // Time step between scans, clustered around the current thresholds.
    function automatic stamp_t pick_delta();
        int unsigned lim;
        case ($urandom_range(0, 3))
            0:       lim = 32'(shadow_cfg.double_click_window);
            1:       lim = 32'(shadow_cfg.long_press_time);
            2:       lim = 32'(shadow_cfg.repeat_period);
            default: lim = 8;
        endcase
        case ($urandom_range(0, 6))
            0:       return stamp_t'($urandom_range(0, 3));
            1:       return stamp_t'(lim - 1);
            2:       return stamp_t'(lim);
            3:       return stamp_t'(lim + 1);
            4:       return stamp_t'($urandom_range(0, lim / 2));
            5:       return stamp_t'($urandom_range(lim / 2, lim));
            default: return stamp_t'($urandom_range(0, 2 * lim + 8));
        endcase
    endfunction

    // Press, optional held scans, release.
    function automatic void add_gesture(logic [KEY_W-1:0] key, int holds, bit quick);
        logic act;
        act = shadow_cfg.active_level_mask[key];
        tick += quick ? stamp_t'($urandom_range(0, 3)) : pick_delta();
        push_scan(key, act, tick);
        repeat (holds)
        begin
            tick += pick_delta();
            push_scan(key, act, tick);
        end
        tick += pick_delta();
        push_scan(key, !act, tick);
    endfunction

    task automatic wait_idle();
        while (scan_q.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ACTIVE_MASK: shadow_cfg.active_level_mask = val[MASK_W-1:0];
            REG_DBL_WINDOW:  shadow_cfg.double_click_window = val;
            REG_LONG_TIME:   shadow_cfg.long_press_time = val;
            REG_REPEAT:      shadow_cfg.repeat_period = val;
            default:         shadow_cfg = shadow_cfg;
        endcase
    endtask

    // Scan sender: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || scan_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (scan_q.size() != 0)
            begin
                s_tdata <= IN_DATA_W'(scan_q.pop_front());
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver: stall pattern switches between modes every so often.
    always @(negedge clk)
    begin
        pat_cnt <= pat_cnt + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (pat_cnt % 7) < 4;
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge clk)
    begin : monitor_proc
        result_t want;
        result_t got;
        if (!rst_n)
            scan_taken <= 1'b0;
        else
        begin
            scan_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got.key_echo = m_tdata[2:0];
                got.event_code = event_t'(m_tdata[5:3]);
                got.press_fired = m_tdata[6];
                got.release_fired = m_tdata[7];
                got.click_fired = m_tdata[8];
                got.double_fired = m_tdata[9];
                got.long_fired = m_tdata[10];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual 0x%04h",
                             $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("key_echo", want.key_echo, got.key_echo);
                    check_field("event_code", want.event_code, got.event_code);
                    check_field("press_fired", want.press_fired, got.press_fired);
                    check_field("release_fired", want.release_fired, got.release_fired);
                    check_field("click_fired", want.click_fired, got.click_fired);
                    check_field("double_fired", want.double_fired, got.double_fired);
                    check_field("long_fired", want.long_fired, got.long_fired);
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_scan(s_tdata[2:0], s_tdata[3],
                                                        s_tdata[35:4]));
        end
    end

    initial
    begin
        logic [KEY_W-1:0] k;
        int               phase_start;
        shadow_cfg.active_level_mask = '0;
        shadow_cfg.double_click_window = DBL_WINDOW_RST;
        shadow_cfg.long_press_time = LONG_TIME_RST;
        shadow_cfg.repeat_period = REPEAT_RST;
        for (int i = 0; i < NUM_KEYS; i++)
            key_st[i] = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Defaults: low level is pressed.
        push_scan(3'd0, 1'b1, 32'd50);
        push_scan(3'd0, 1'b0, 32'd100);
        push_scan(3'd0, 1'b0, 32'd200);
        push_scan(3'd0, 1'b1, 32'd250);
        push_scan(3'd0, 1'b0, 32'd300);
        push_scan(3'd0, 1'b1, 32'd350);
        // Hold across the time wrap: repeat, then repeat plus long, then release.
        push_scan(3'd7, 1'b0, 32'hFFFF_FF00);
        push_scan(3'd7, 1'b0, 32'h0000_0090);
        push_scan(3'd7, 1'b0, 32'h0000_0220);
        push_scan(3'd7, 1'b1, 32'h0000_0300);
        // Second click exactly at the window is a new first click, then a double.
        push_scan(3'd3, 1'b0, 32'd900);
        push_scan(3'd3, 1'b1, 32'd1000);
        push_scan(3'd3, 1'b0, 32'd1100);
        push_scan(3'd3, 1'b1, 32'd1400);
        push_scan(3'd3, 1'b0, 32'd1500);
        push_scan(3'd3, 1'b1, 32'd1799);
        push_scan(3'd5, 1'b0, 32'hFFFF_FFFF);
        push_scan(3'd5, 1'b1, 32'h0000_0000);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            if (p == 0)
            begin
                write_reg(REG_ACTIVE_MASK, 16'h00FF);
                write_reg(REG_DBL_WINDOW, 16'd0);
                write_reg(REG_LONG_TIME, 16'd0);
                write_reg(REG_REPEAT, 16'd0);
            end
            else if (p == 1)
            begin
                write_reg(REG_ACTIVE_MASK, 16'h0000);
                write_reg(REG_DBL_WINDOW, 16'hFFFF);
                write_reg(REG_LONG_TIME, 16'hFFFF);
                write_reg(REG_REPEAT, 16'hFFFF);
            end
            else
            begin
                write_reg(REG_ACTIVE_MASK, CFG_W'($urandom_range(0, 255)));
                write_reg(REG_DBL_WINDOW, CFG_W'($urandom_range(1, 1500)));
                write_reg(REG_LONG_TIME, CFG_W'($urandom_range(1, 2000)));
                write_reg(REG_REPEAT, CFG_W'($urandom_range(1, 1000)));
            end
            @(negedge clk);
            cfg_wr_en <= 1'b0;

            case ($urandom_range(0, 2))
                0:       tick = '0;
                1:       tick = stamp_t'(-$urandom_range(1, 3000));
                default: tick = stamp_t'($urandom);
            endcase

            if (p == 0)
            begin
                // Zero long press time: long press in the press scan itself.
                push_scan(3'd2, 1'b1, tick);
                push_scan(3'd2, 1'b1, tick);
                push_scan(3'd2, 1'b0, tick + 1);
            end

            phase_start = scans_queued;
            while (scans_queued - phase_start < ITEMS_PER_PHASE)
            begin
                k = KEY_W'($urandom_range(0, NUM_KEYS - 1));
                case ($urandom_range(0, 9))
                    0, 1:
                        push_scan(KEY_W'($urandom_range(0, NUM_KEYS - 1)),
                                  1'($urandom_range(0, 1)),
                                  $urandom_range(0, 1) ? stamp_t'($urandom)
                                                       : tick + stamp_t'($urandom_range(0, 4)));
                    2, 3, 4:
                    begin
                        add_gesture(k, 0, 1'b0);
                        add_gesture(k, ($urandom_range(0, 3) == 0) ? 1 : 0, 1'b1);
                    end
                    default:
                        add_gesture(k, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5)
                                                                  : $urandom_range(0, 1),
                                    1'b0);
                endcase
            end
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results still expected, actual none",
                     $time, expected_results.size());
            fail_count++;
        end
        $display("Ran %0d scans under %0d register settings, %0d results compared",
                 scans_queued, NUM_PHASES + 1, results_seen);
        $display("Predicted fires: press %0d, release %0d, click %0d, double %0d, long %0d",
                 n_press, n_release, n_click, n_double, n_long);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
